// ===== hdl/free_block_sort_and_coalesce_defines.svh =====
`ifndef FREE_BLOCK_SORT_AND_COALESCE_DEFINES_SVH
`define FREE_BLOCK_SORT_AND_COALESCE_DEFINES_SVH

// property checked on every clock edge outside reset
`define FBSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication into the next cycle
`define FBSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/fbsc_pkg.sv =====
package fbsc_pkg;

	localparam int ADDR_W = 32;
	localparam int COUNT_OUT_W = 6;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_COUNT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic init_count;
		logic init_emit;
		logic count_step;
		logic emit_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic count_done;
		logic emit_done;
	} sts_t;

endpackage

// ===== hdl/free_block_sort_and_coalesce.sv =====
// free block sort and coalesce
// input channel (in_valid/in_ready): one free block per beat, block_address and
// block_size, with last_block on the final beat of a list. blocks load at one
// beat per cycle and are kept in address order as they arrive, so in_ready is
// high for the whole list.
// after the last beat in_ready drops. a counting pass walks the sorted row and
// finds the number of merged blocks and the largest merged size; an emit pass
// of stored + 1 steps then sends the merged blocks.
// output channel (out_valid/out_ready): one merged block per beat in address
// order, last_result on the final beat; largest_size, merged_count and overflow
// are the same on every beat of the run.
// a stalled receiver holds the emit pass; the result register keeps its beat.
// blocks beyond MAX_BLOCKS are dropped and overflow is flagged for that list.
// reset empties the list and clears out_valid; no clearing pass is needed.
module free_block_sort_and_coalesce #(
	parameter int MAX_BLOCKS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [fbsc_pkg::ADDR_W-1:0]      block_address,
	input  logic [fbsc_pkg::ADDR_W-1:0]      block_size,
	input  logic                             last_block,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [fbsc_pkg::ADDR_W-1:0]      merged_address,
	output logic [fbsc_pkg::ADDR_W-1:0]      merged_size,
	output logic [fbsc_pkg::ADDR_W-1:0]      largest_size,
	output logic [fbsc_pkg::COUNT_OUT_W-1:0] merged_count,
	output logic                             overflow,
	output logic                             last_result
);

	fbsc_pkg::cmd_t cmd;
	fbsc_pkg::sts_t sts;

	fbsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_block (last_block),
		.in_ready   (in_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	fbsc_datapath #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.block_address  (block_address),
		.block_size     (block_size),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.merged_address (merged_address),
		.merged_size    (merged_size),
		.largest_size   (largest_size),
		.merged_count   (merged_count),
		.overflow       (overflow),
		.last_result    (last_result)
	);

endmodule

// ===== hdl/fbsc_ctrl.sv =====
module fbsc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last_block,
	output logic           in_ready,
	input  fbsc_pkg::sts_t sts,
	output fbsc_pkg::cmd_t cmd
);

	fbsc_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbsc_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fbsc_pkg::ST_LOAD: begin
				if (in_valid && last_block) state_nxt = fbsc_pkg::ST_COUNT;
			end
			fbsc_pkg::ST_COUNT: begin
				if (sts.count_done) state_nxt = fbsc_pkg::ST_EMIT;
			end
			fbsc_pkg::ST_EMIT: begin
				if (sts.emit_done) state_nxt = fbsc_pkg::ST_LOAD;
			end
			default: state_nxt = fbsc_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			fbsc_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.init_count = in_valid && last_block;
			end
			fbsc_pkg::ST_COUNT: begin
				cmd.count_step = 1'b1;
				cmd.init_emit = sts.count_done;
			end
			fbsc_pkg::ST_EMIT: begin
				cmd.emit_step = 1'b1;
				cmd.finish = sts.emit_done;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hdl/fbsc_datapath.sv =====
module fbsc_datapath #(
	parameter int MAX_BLOCKS = 32,
	parameter int CW = $clog2(MAX_BLOCKS + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fbsc_pkg::cmd_t                      cmd,
	output fbsc_pkg::sts_t                      sts,
	input  logic [fbsc_pkg::ADDR_W-1:0]         block_address,
	input  logic [fbsc_pkg::ADDR_W-1:0]         block_size,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fbsc_pkg::ADDR_W-1:0]         merged_address,
	output logic [fbsc_pkg::ADDR_W-1:0]         merged_size,
	output logic [fbsc_pkg::ADDR_W-1:0]         largest_size,
	output logic [fbsc_pkg::COUNT_OUT_W-1:0]    merged_count,
	output logic                                overflow,
	output logic                                last_result
);

	localparam int AW = fbsc_pkg::ADDR_W;

	logic [AW-1:0] addr_q [MAX_BLOCKS];
	logic [AW-1:0] size_q [MAX_BLOCKS];
	logic [AW-1:0] addr_ins [MAX_BLOCKS];
	logic [AW-1:0] size_ins [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] gt;

	logic [CW-1:0] n_q, idx_q, runs_q;
	logic          ovf_q;
	logic [AW-1:0] start_q, largest_q;
	logic [AW:0]   end_q, diff;
	logic [AW-1:0] sat;
	logic          valid_ent, first, chain, close, out_free, step1, step2, step, full;

	// sorted insert, equal addresses stay behind earlier ones
	always_comb begin
		for (int k = 0; k < MAX_BLOCKS; k++) begin
			gt[k] = (CW'(k) < n_q) && (addr_q[k] > block_address);
		end
		for (int k = 0; k < MAX_BLOCKS; k++) begin
			if (gt[k] || (CW'(k) == n_q)) begin
				if (k > 0 && gt[(k > 0) ? k - 1 : 0]) begin
					addr_ins[k] = addr_q[(k > 0) ? k - 1 : 0];
					size_ins[k] = size_q[(k > 0) ? k - 1 : 0];
				end else begin
					addr_ins[k] = block_address;
					size_ins[k] = block_size;
				end
			end else begin
				addr_ins[k] = addr_q[k];
				size_ins[k] = size_q[k];
			end
		end
	end

	assign full      = (n_q == CW'(MAX_BLOCKS));
	assign valid_ent = idx_q < n_q;
	assign first     = (idx_q == '0);
	assign chain     = !first && valid_ent && (end_q == {1'b0, addr_q[0]});
	assign close     = !first && !chain && (idx_q <= n_q);
	assign diff      = end_q - {1'b0, start_q};
	assign sat       = diff[AW] ? '1 : diff[AW-1:0];
	assign out_free  = !out_valid || out_ready;
	assign step1     = cmd.count_step;
	assign step2     = cmd.emit_step && out_free;
	assign step      = step1 || step2;

	assign sts.count_done = (idx_q == CW'(MAX_BLOCKS));
	assign sts.emit_done  = step2 && (idx_q == n_q);

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			for (int k = 0; k < MAX_BLOCKS; k++) begin
				addr_q[k] <= addr_ins[k];
				size_q[k] <= size_ins[k];
			end
		end else if (step && (idx_q < CW'(MAX_BLOCKS))) begin
			for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
				addr_q[k] <= addr_q[k+1];
				size_q[k] <= size_q[k+1];
			end
			addr_q[MAX_BLOCKS-1] <= addr_q[0];
			size_q[MAX_BLOCKS-1] <= size_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			ovf_q     <= 1'b0;
			idx_q     <= '0;
			runs_q    <= '0;
			largest_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (!full) n_q <= n_q + 1'b1;
				else       ovf_q <= 1'b1;
			end else if (cmd.finish) begin
				n_q   <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.init_count || cmd.init_emit) idx_q <= '0;
			else if (step)                       idx_q <= idx_q + 1'b1;
			if (cmd.init_count) begin
				runs_q    <= '0;
				largest_q <= '0;
			end else if (step1 && close) begin
				runs_q <= runs_q + 1'b1;
				if (sat > largest_q) largest_q <= sat;
			end
			if (step2 && close)  out_valid <= 1'b1;
			else if (out_ready)  out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && valid_ent) begin
			if (chain) begin
				end_q <= end_q + {1'b0, size_q[0]};
			end else begin
				start_q <= addr_q[0];
				end_q   <= {1'b0, addr_q[0]} + {1'b0, size_q[0]};
			end
		end
		if (step2 && close) begin
			merged_address <= start_q;
			merged_size    <= sat;
			largest_size   <= largest_q;
			merged_count   <= fbsc_pkg::COUNT_OUT_W'(runs_q);
			overflow       <= ovf_q;
			last_result    <= (idx_q == n_q);
		end
	end

endmodule

// ===== hdl/fbsc_checker.sv =====
`include "free_block_sort_and_coalesce_defines.svh"

module fbsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        last_block,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] merged_address,
	input logic [5:0]  merged_count,
	input logic        last_result
);

	`FBSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(merged_address), "result beat changed while stalled")
	`FBSC_ASSERT(a_count_nonzero, !out_valid || (merged_count != 6'd0), "result beat with zero count")
	`FBSC_ASSERT_NEXT(a_gap_after_last, out_valid && out_ready && last_result, !out_valid, "result beat right after final beat")
	`FBSC_ASSERT_NEXT(a_busy_after_list, in_valid && in_ready && last_block, !in_ready, "input taken right after last block")

endmodule

bind free_block_sort_and_coalesce fbsc_checker u_fbsc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.last_block     (last_block),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.merged_address (merged_address),
	.merged_count   (merged_count),
	.last_result    (last_result)
);
